>>> hw/rtl/u2cp_pkg.sv
// ----------------------------------------------------------------------------
// u2cp_pkg
// Shared widths and constants of the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
package u2cp_pkg;

	localparam int BYTE_W     = 8;
	localparam int CP_W       = 22;
	localparam int LEN_W      = 16;
	localparam int REM_W      = 2;
	localparam int TAB_WIDTH  = 4;
	localparam int RESULT_CAP = 4;
	localparam int REP_W      = $clog2(RESULT_CAP + 1);
	localparam int CONT_SHIFT = 6;

	localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 16'd65534;

	localparam int TAB_LIM_FULL_I  = (TAB_WIDTH < RESULT_CAP) ? TAB_WIDTH : RESULT_CAP;
	localparam int TAB_LIM_FLUSH_I = (TAB_WIDTH < RESULT_CAP - 1) ? TAB_WIDTH : RESULT_CAP - 1;
	localparam logic [REP_W-1:0] TAB_LIM_FULL  = REP_W'(TAB_LIM_FULL_I);
	localparam logic [REP_W-1:0] TAB_LIM_FLUSH = REP_W'(TAB_LIM_FLUSH_I);

	localparam logic [3:0] NIB_LEAD4  = 4'hF;
	localparam logic [3:0] NIB_LEAD3  = 4'hE;
	localparam logic [3:0] NIB_LEAD2A = 4'hC;
	localparam logic [3:0] NIB_LEAD2B = 4'hD;

	localparam logic [BYTE_W-1:0] MARK_LEAD4 = 8'hF0;
	localparam logic [BYTE_W-1:0] MARK_LEAD3 = 8'hE0;
	localparam logic [BYTE_W-1:0] MARK_LEAD2 = 8'hC0;
	localparam logic [BYTE_W-1:0] MARK_CONT  = 8'h80;
	localparam logic [BYTE_W-1:0] MARK_NONE  = 8'h00;

	localparam logic [CP_W-1:0] CP_TAB   = 22'd9;
	localparam logic [CP_W-1:0] CP_CR    = 22'd13;
	localparam logic [CP_W-1:0] CP_SPACE = 22'h20;

endpackage

>>> hw/rtl/utf8_to_codepoint_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder
// UTF-8 byte stream in, one code point per output transaction, terminator on
// the zero byte.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle unless a byte with results waits for a
// busy result register; an accepted byte is registered in byte_s1 before its
// results load the result register. Each byte yields at most four output
// transactions, handed out by the single result register at one per cycle
// while out_ready is high: a tab expands to up to four spaces, and a zero
// byte that closes a truncated sequence gives the flushed value, if any, then
// the terminator. Bytes that yield nothing (non-final continuation bytes,
// carriage returns, bytes past max_length) skip the result register. The
// max_length register is written over the cfg channel, which is always ready.
module utf8_to_codepoint_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [u2cp_pkg::LEN_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [u2cp_pkg::BYTE_W-1:0]   byte_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [u2cp_pkg::CP_W-1:0]     code_point,
	output logic                          is_end
);

	logic [u2cp_pkg::LEN_W-1:0]  max_q;
	logic [u2cp_pkg::CP_W-1:0]   partial_q;
	logic [u2cp_pkg::REM_W-1:0]  rem_q;
	logic [u2cp_pkg::LEN_W-1:0]  count_q;
	logic                        limit_q;

	logic                        valid_s1;
	logic [u2cp_pkg::BYTE_W-1:0] byte_s1;

	logic [u2cp_pkg::CP_W-1:0]   value_q;
	logic [u2cp_pkg::REP_W-1:0]  rep_q;
	logic                        term_q;

	logic                        is_zero;
	logic [u2cp_pkg::BYTE_W-1:0] marker;
	logic [u2cp_pkg::REM_W-1:0]  lead_rem;
	logic [u2cp_pkg::CP_W-1:0]   cont_val;
	logic [u2cp_pkg::REM_W-1:0]  rem_dec;
	logic                        at_limit;
	logic                        fin_do;
	logic [u2cp_pkg::CP_W-1:0]   fin_v;
	logic [u2cp_pkg::LEN_W-1:0]  room;
	logic [u2cp_pkg::REP_W-1:0]  tab_lim;
	logic [u2cp_pkg::REP_W-1:0]  tab_k;
	logic [u2cp_pkg::REP_W-1:0]  n_emit;
	logic [u2cp_pkg::LEN_W-1:0]  count_fin;

	logic [u2cp_pkg::CP_W-1:0]   partial_d;
	logic [u2cp_pkg::REM_W-1:0]  rem_d;
	logic [u2cp_pkg::LEN_W-1:0]  count_d;
	logic                        limit_d;
	logic [u2cp_pkg::CP_W-1:0]   res_value;
	logic [u2cp_pkg::REP_W-1:0]  res_rep;
	logic                        res_term;
	logic                        has_results;

	logic                        out_fire;
	logic                        out_last;
	logic                        res_free;
	logic                        s1_adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= u2cp_pkg::MAX_LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_q <= cfg_data;
		end
	end

	always_comb begin
		marker   = u2cp_pkg::MARK_NONE;
		lead_rem = '0;
		case (byte_s1[7:4]) inside
			u2cp_pkg::NIB_LEAD4: begin
				marker   = u2cp_pkg::MARK_LEAD4;
				lead_rem = 2'd3;
			end
			u2cp_pkg::NIB_LEAD3: begin
				marker   = u2cp_pkg::MARK_LEAD3;
				lead_rem = 2'd2;
			end
			u2cp_pkg::NIB_LEAD2A, u2cp_pkg::NIB_LEAD2B: begin
				marker   = u2cp_pkg::MARK_LEAD2;
				lead_rem = 2'd1;
			end
			default: begin
				marker   = u2cp_pkg::MARK_NONE;
				lead_rem = '0;
			end
		endcase
	end

	assign is_zero  = (byte_s1 == '0);
	assign cont_val = (partial_q << u2cp_pkg::CONT_SHIFT)
		| {{(u2cp_pkg::CP_W-u2cp_pkg::BYTE_W){1'b0}}, byte_s1 ^ u2cp_pkg::MARK_CONT};
	assign rem_dec  = rem_q - 2'd1;
	assign at_limit = limit_q || (count_q >= max_q);

	always_comb begin
		fin_do = 1'b0;
		fin_v  = partial_q;
		if (is_zero) begin
			fin_do = (rem_q != '0);
			fin_v  = partial_q;
		end else if (rem_q != '0) begin
			fin_do = (rem_dec == '0);
			fin_v  = cont_val;
		end else if (!at_limit) begin
			fin_do = (lead_rem == '0);
			fin_v  = {{(u2cp_pkg::CP_W-u2cp_pkg::BYTE_W){1'b0}}, byte_s1 ^ marker};
		end
	end

	assign room    = (count_q >= max_q) ? '0 : max_q - count_q;
	assign tab_lim = is_zero ? u2cp_pkg::TAB_LIM_FLUSH : u2cp_pkg::TAB_LIM_FULL;
	assign tab_k   = (room < {{(u2cp_pkg::LEN_W-u2cp_pkg::REP_W){1'b0}}, tab_lim})
		? room[u2cp_pkg::REP_W-1:0] : tab_lim;

	always_comb begin
		if (!fin_do || fin_v == u2cp_pkg::CP_CR) begin
			n_emit = '0;
		end else if (fin_v == u2cp_pkg::CP_TAB) begin
			n_emit = tab_k;
		end else begin
			n_emit = (room != '0) ? u2cp_pkg::REP_W'(1) : '0;
		end
	end

	assign count_fin = count_q + {{(u2cp_pkg::LEN_W-u2cp_pkg::REP_W){1'b0}}, n_emit};

	always_comb begin
		partial_d = partial_q;
		rem_d     = rem_q;
		count_d   = count_fin;
		limit_d   = limit_q || (fin_do && (count_fin >= max_q));
		res_term  = 1'b0;
		if (is_zero) begin
			partial_d = '0;
			rem_d     = '0;
			count_d   = '0;
			limit_d   = 1'b0;
			res_term  = 1'b1;
		end else if (rem_q != '0) begin
			partial_d = (rem_dec == '0) ? '0 : cont_val;
			rem_d     = rem_dec;
		end else if (at_limit) begin
			count_d = count_q;
			limit_d = 1'b1;
		end else begin
			partial_d = (lead_rem == '0) ? '0 : fin_v;
			rem_d     = lead_rem;
		end
	end

	assign res_value   = (fin_v == u2cp_pkg::CP_TAB) ? u2cp_pkg::CP_SPACE : fin_v;
	assign res_rep     = n_emit;
	assign has_results = res_term || (res_rep != '0);

	assign out_valid  = (rep_q != '0) || term_q;
	assign code_point = (rep_q != '0) ? value_q : '0;
	assign is_end     = (rep_q == '0) && term_q;
	assign out_fire   = out_valid && out_ready;
	assign out_last   = ((rep_q == u2cp_pkg::REP_W'(1)) && !term_q) || ((rep_q == '0) && term_q);
	assign res_free   = !out_valid || (out_fire && out_last);
	assign s1_adv     = valid_s1 && (!has_results || res_free);
	assign in_ready   = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			rem_q     <= '0;
			count_q   <= '0;
			limit_q   <= 1'b0;
		end else if (s1_adv) begin
			partial_q <= partial_d;
			rem_q     <= rem_d;
			count_q   <= count_d;
			limit_q   <= limit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q  <= '0;
			term_q <= 1'b0;
		end else if (s1_adv && has_results) begin
			rep_q  <= res_rep;
			term_q <= res_term;
		end else if (out_fire) begin
			if (rep_q != '0) begin
				rep_q <= rep_q - u2cp_pkg::REP_W'(1);
			end else begin
				term_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && has_results) begin
			value_q <= res_value;
		end
	end

	a_bundle_cap: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, rep_q} + {{u2cp_pkg::REP_W{1'b0}}, term_q}) <= (u2cp_pkg::REP_W+1)'(u2cp_pkg::RESULT_CAP))
		else $error("result bundle exceeds the per-byte cap");

	a_idle_partial: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q == '0) |-> (partial_q == '0))
		else $error("partial value left over with no sequence open");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && is_zero) |=> (count_q == '0 && rem_q == '0 && !limit_q && term_q))
		else $error("zero byte did not close the string");

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the UTF-8 to code point decoder. Bytes go in over a
// valid/ready channel with random gaps and code points come out through a
// randomly stalled sink. The checker compares each of them with a software
// decoder that runs on every accepted byte. Directed tests cover single
// bytes, multi-byte and malformed sequences, and the max_length limit.
// Random strings then run under several max_length settings.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [u2cp_pkg::BYTE_W-1:0] B_NUL = 8'h00;
	localparam logic [u2cp_pkg::BYTE_W-1:0] B_TAB = 8'h09;
	localparam logic [u2cp_pkg::BYTE_W-1:0] B_CR  = 8'h0D;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [u2cp_pkg::CP_W-1:0] cp;
		logic                      last;
	} cp_result_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [u2cp_pkg::LEN_W-1:0]  cfg_data  = '0;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	logic [u2cp_pkg::BYTE_W-1:0] byte_in   = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [u2cp_pkg::CP_W-1:0]   code_point;
	logic                        is_end;

	cp_result_t                  expected_cps[$];
	int                          fail_count = 0;
	int                          bytes_sent = 0;
	bit                          tx_idle    = 1'b1;
	bit                          rx_idle    = 1'b1;

	logic [u2cp_pkg::LEN_W-1:0]  max_len    = u2cp_pkg::MAX_LENGTH_RESET;
	logic [u2cp_pkg::CP_W-1:0]   asm_value  = '0;
	logic [u2cp_pkg::REM_W-1:0]  owed_bytes = '0;
	logic [u2cp_pkg::LEN_W-1:0]  emitted    = '0;
	bit                          at_limit   = 1'b0;

	utf8_to_codepoint_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.byte_in   (byte_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.code_point(code_point),
		.is_end    (is_end)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void push_cp(logic [u2cp_pkg::CP_W-1:0] cp, logic last);
		cp_result_t r;
		r.cp   = cp;
		r.last = last;
		expected_cps.insert(expected_cps.size(), r);
	endfunction

	function automatic void emit_value(logic [u2cp_pkg::CP_W-1:0] v, int cap);
		logic [u2cp_pkg::LEN_W-1:0] room;
		int                         k;
		room = (emitted >= max_len) ? '0 : max_len - emitted;
		if (v == u2cp_pkg::CP_TAB) begin
			k = u2cp_pkg::TAB_WIDTH;
			if (k > int'(room)) k = int'(room);
			if (k > cap) k = cap;
			repeat (k) begin
				push_cp(u2cp_pkg::CP_SPACE, 1'b0);
				emitted++;
			end
		end else if (v != u2cp_pkg::CP_CR && room != 0 && cap > 0) begin
			push_cp(v, 1'b0);
			emitted++;
		end
		if (emitted >= max_len) at_limit = 1'b1;
	endfunction

	function automatic void decode_byte(logic [u2cp_pkg::BYTE_W-1:0] b);
		logic [u2cp_pkg::BYTE_W-1:0] marker;
		logic [u2cp_pkg::REM_W-1:0]  tail;
		if (b == B_NUL) begin
			if (owed_bytes != 0) emit_value(asm_value, u2cp_pkg::RESULT_CAP - 1);
			push_cp('0, 1'b1);
			asm_value  = '0;
			owed_bytes = '0;
			emitted    = '0;
			at_limit   = 1'b0;
			return;
		end
		if (owed_bytes != 0) begin
			asm_value = (asm_value << u2cp_pkg::CONT_SHIFT)
				| u2cp_pkg::CP_W'(b ^ u2cp_pkg::MARK_CONT);
			owed_bytes--;
			if (owed_bytes == 0) begin
				emit_value(asm_value, u2cp_pkg::RESULT_CAP);
				asm_value = '0;
			end
			return;
		end
		if (at_limit || emitted >= max_len) begin
			at_limit = 1'b1;
			return;
		end
		case (b[7:4])
			u2cp_pkg::NIB_LEAD4: begin
				marker = u2cp_pkg::MARK_LEAD4;
				tail   = 2'd3;
			end
			u2cp_pkg::NIB_LEAD3: begin
				marker = u2cp_pkg::MARK_LEAD3;
				tail   = 2'd2;
			end
			u2cp_pkg::NIB_LEAD2A, u2cp_pkg::NIB_LEAD2B: begin
				marker = u2cp_pkg::MARK_LEAD2;
				tail   = 2'd1;
			end
			default: begin
				marker = u2cp_pkg::MARK_NONE;
				tail   = 2'd0;
			end
		endcase
		asm_value  = u2cp_pkg::CP_W'(b ^ marker);
		owed_bytes = tail;
		if (owed_bytes == 0) begin
			emit_value(asm_value, u2cp_pkg::RESULT_CAP);
			asm_value = '0;
		end
	endfunction

	task automatic send_byte(input logic [u2cp_pkg::BYTE_W-1:0] b);
		int gap;
		gap = tx_idle ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		byte_in  <= b;
		do @(posedge clk); while (!in_ready);
		decode_byte(b);
		bytes_sent++;
	endtask

	// lead byte of the given length, then n_cont continuation bytes (random nonzero bytes unless sound)
	task automatic send_sequence(input int len, input int n_cont, input bit sound);
		logic [u2cp_pkg::BYTE_W-1:0] lead;
		int                          i;
		case (len)
			2:       lead = u2cp_pkg::MARK_LEAD2 | u2cp_pkg::BYTE_W'($urandom_range(0, 31));
			3:       lead = u2cp_pkg::MARK_LEAD3 | u2cp_pkg::BYTE_W'($urandom_range(0, 15));
			4:       lead = u2cp_pkg::MARK_LEAD4 | u2cp_pkg::BYTE_W'($urandom_range(0, 15));
			default: lead = u2cp_pkg::BYTE_W'($urandom_range(1, 127));
		endcase
		send_byte(lead);
		for (i = 0; i < n_cont; i++) begin
			if (sound) send_byte(u2cp_pkg::MARK_CONT | u2cp_pkg::BYTE_W'($urandom_range(0, 63)));
			else send_byte(u2cp_pkg::BYTE_W'($urandom_range(1, 255)));
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_cps.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_max_length(input logic [u2cp_pkg::LEN_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_len = v;
	endtask

	task automatic test_single_bytes();
		send_byte(8'h01);
		send_byte(8'h7F);
		send_byte(8'h80);
		send_byte(8'hBF);
		send_byte(B_TAB);
		send_byte(B_CR);
		send_byte(B_NUL);
	endtask

	task automatic test_sequences();
		send_byte(8'hC3); send_byte(8'hA9);
		send_byte(8'hD5); send_byte(8'hB0);
		send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAC);
		send_byte(8'hFF); send_byte(8'hBF); send_byte(8'hBF); send_byte(8'hBF);
		send_byte(8'hC3); send_byte(8'h41);
		send_byte(8'hC0); send_byte(8'h89);
		send_byte(8'hE0); send_byte(8'h89); send_byte(B_NUL);
	endtask

	task automatic test_limits();
		write_max_length(16'd3);
		send_byte(8'h61); send_byte(8'h62); send_byte(B_TAB); send_byte(8'h63);
		send_byte(B_NUL);
		write_max_length(16'd0);
		send_byte(8'h61); send_byte(B_NUL);
		write_max_length(u2cp_pkg::MAX_LENGTH_RESET);
		send_byte(8'h61); send_byte(8'hC3);
		write_max_length(16'd1);
		send_byte(8'hA9); send_byte(B_NUL);
	endtask

	task automatic send_random_string();
		int n;
		int i;
		int len;
		bit noisy;
		n     = $urandom_range(0, 8);
		noisy = ($urandom_range(0, 7) == 0);
		for (i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_byte(u2cp_pkg::BYTE_W'($urandom_range(1, 127)));
				4:          send_byte(B_TAB);
				5:          send_byte(B_CR);
				6:          send_sequence(2, 1, !noisy);
				7:          send_sequence(3, 2, !noisy);
				8:          send_sequence(4, 3, !noisy);
				default:    send_byte(u2cp_pkg::BYTE_W'($urandom_range(1, 255)));
			endcase
		end
		if ($urandom_range(0, 5) == 0) begin
			len = $urandom_range(2, 4);
			send_sequence(len, $urandom_range(0, len - 2), 1'b1);
		end
		send_byte(B_NUL);
	endtask

	task automatic test_random_strings();
		int p;
		int phase_end;
		for (p = 0; p < 8; p++) begin
			case (p % 4)
				0:       write_max_length(u2cp_pkg::MAX_LENGTH_RESET);
				1:       write_max_length(16'd1);
				default: write_max_length(u2cp_pkg::LEN_W'($urandom_range(2, 12)));
			endcase
			tx_idle   = (p != 2 && p != 6);
			rx_idle   = (p != 2 && p != 5);
			phase_end = bytes_sent + 20;
			while (bytes_sent < phase_end) send_random_string();
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	initial begin : result_sink
		int         stall;
		cp_result_t exp_cp;
		bit         bad;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_idle ? $urandom_range(0, 7) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			if (expected_cps.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected transaction: code_point %06h is_end %b",
						code_point, is_end);
			end else begin
				exp_cp = expected_cps.pop_front();
				bad    = 1'b0;
				if (code_point !== exp_cp.cp) bad = 1'b1;
				if (is_end !== exp_cp.last) bad = 1'b1;
				if (bad) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("mismatch: code_point exp %06h got %06h, is_end exp %b got %b",
							exp_cp.cp, code_point, exp_cp.last, is_end);
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_bytes();
		test_sequences();
		test_limits();
		test_random_strings();
		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && expected_cps.size() == 0) begin
			$display("[utf8_to_codepoint_decoder] OK");
		end else begin
			$display("[utf8_to_codepoint_decoder] ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d code points outstanding", expected_cps.size());
		$display("[utf8_to_codepoint_decoder] ERROR");
		$finish;
	end

endmodule
